// ===== rtl/dsr_pkg.sv =====
`default_nettype none

package dsr_pkg;

   // widths fixed by the line format and register map
   localparam int SLOT_W   = 10;
   localparam int BYTE_W   = 8;
   localparam int FRAME_W  = 6;
   localparam int CSR_IDX_W = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OWN_ADDRESS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_LIMIT  = 8'd1;

   localparam logic [SLOT_W-1:0] OWN_ADDRESS_RESET = 10'd1;
   localparam logic [SLOT_W-1:0] SLOT_LIMIT_RESET  = 10'd513;
   localparam logic [SLOT_W-1:0] SLOT_MAX          = 10'd1023;

   // start codes
   localparam logic [BYTE_W-1:0] START_POLL = 8'hF7;
   localparam logic [BYTE_W-1:0] START_DATA = 8'h00;

   // result queue
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   typedef enum logic {
      RES_BREAK,
      RES_FRAME
   } res_kind_type;

   // handed from the front to the back, registered in the same cycle as the store read data
   typedef struct packed {
      res_kind_type         kind;
      logic                 level_valid;
      logic                 activity;
      logic                 poll;
      logic                 rd_ok;
      logic                 fwd;
      logic [BYTE_W-1:0]    fwd_data;
   } desc_type;

   typedef struct packed {
      logic                 poll_active;
      logic                 ack_request;
      logic                 activity_pulse;
      logic                 level_valid;
      logic [BYTE_W-1:0]    level;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/dmx512_slot_receiver.sv =====
`default_nettype none

// channel  direction  tdata (lsb first)                          tuser
// req      in         rx_byte[7:0]                               break_seen
// rsp      out        level[7:0], activity_pulse, ack_request,   level_valid
//                     poll_active, zero pad to 16 bits
// csr      in         index 0 own_address, 1 slot_limit (10 bits)
//
// one item per cycle while req_tready is high; a result passes the front register
// and the store read register, which load together, and then the result queue
// the store needs no clearing pass: a fill mark makes unwritten slots read as zero
// the front stalls only when the result queue and the read stage together hold four items
// reset is synchronous and clears all control state and the fill mark

module dmx512_slot_receiver #(
   parameter int UNIVERSE_SLOTS  = 513,
   parameter int ACTIVITY_FRAMES = 45
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // rx_byte[7:0]
   input  wire logic [7:0]                         req_tdata,
   // break_seen
   input  wire logic                               req_tuser,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // level[7:0], activity_pulse, ack_request, poll_active, zeros
   output logic      [15:0]                        rsp_tdata,
   // level_valid
   output logic                                    rsp_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dsr_pkg::SLOT_W-1:0]         csr_data
);

   localparam int AW = $clog2(UNIVERSE_SLOTS);

   logic                          accept;
   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr, ram_rd_addr;
   logic [dsr_pkg::BYTE_W-1:0]    ram_wr_data, ram_q;
   logic                          desc_valid_ff;
   dsr_pkg::desc_type             desc_ff;
   dsr_pkg::result_type           result, rsp_item;
   logic [dsr_pkg::QUEUE_AW:0]    queue_count;
   logic [dsr_pkg::BYTE_W-1:0]    own_level;

   // configuration is always taken
   assign csr_ready = 1'b1;

   // leave room for the item in the read stage
   assign req_tready = (queue_count + {2'b00, desc_valid_ff})
                       < (dsr_pkg::QUEUE_AW + 1)'(dsr_pkg::QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;

   dsr_front #(
      .UNIVERSE_SLOTS  (UNIVERSE_SLOTS),
      .ACTIVITY_FRAMES (ACTIVITY_FRAMES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_tdata),
      .break_seen    (req_tuser),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr   (ram_rd_addr),
      .desc_valid_ff (desc_valid_ff),
      .desc_ff       (desc_ff)
   );

   dsr_ram #(
      .WIDTH (dsr_pkg::BYTE_W),
      .DEPTH (UNIVERSE_SLOTS)
   ) u_store (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_q)
   );

   // back end: own slot level with write forwarding, then the result fields
   always_comb begin
      own_level = '0;
      if (desc_ff.rd_ok) begin
         own_level = desc_ff.fwd ? desc_ff.fwd_data : ram_q;
      end
      result             = '0;
      result.poll_active = desc_ff.poll;
      case (desc_ff.kind)
         dsr_pkg::RES_BREAK: begin
            result.level_valid = desc_ff.level_valid;
            result.level       = desc_ff.level_valid ? own_level : '0;
         end
         default: begin
            result.activity_pulse = desc_ff.activity;
            result.ack_request    = desc_ff.poll && (own_level == 8'd1);
         end
      endcase
   end

   dsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_valid_ff),
      .push_data (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_item),
      .count_ff  (queue_count)
   );

   assign rsp_tdata = {5'b00000, rsp_item.poll_active, rsp_item.ack_request,
                       rsp_item.activity_pulse, rsp_item.level};
   assign rsp_tuser = rsp_item.level_valid;

   // a level report only comes outside poll mode
   a_level_not_in_poll: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.level_valid |-> !rsp_item.poll_active)
      else $error("level reported while poll mode active");

   // break results never carry frame flags; checked on the level reports
   a_break_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.level_valid
         |-> !rsp_item.activity_pulse && !rsp_item.ack_request)
      else $error("frame flag on a level report");

   a_ack_needs_poll: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.ack_request |-> rsp_item.poll_active)
      else $error("acknowledge request outside poll mode");

   a_level_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_item.level_valid |-> rsp_item.level == '0)
      else $error("level not zero without level_valid");

   // queue never overruns: the ready term reserves the read stage
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= (dsr_pkg::QUEUE_AW + 1)'(dsr_pkg::QUEUE_DEPTH))
      else $error("result queue overrun");

endmodule

`default_nettype wire

// ===== rtl/dsr_ram.sv =====
`default_nettype none

module dsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 513
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/dsr_front.sv =====
`default_nettype none

module dsr_front #(
   parameter int UNIVERSE_SLOTS  = 513,
   parameter int ACTIVITY_FRAMES = 45
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  accept,
   input  wire logic [dsr_pkg::BYTE_W-1:0]            rx_byte,
   input  wire logic                                  break_seen,
   input  wire logic                                  csr_write,
   input  wire logic [dsr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [dsr_pkg::SLOT_W-1:0]            csr_data,
   output logic                                       ram_wr_en,
   output logic      [$clog2(UNIVERSE_SLOTS)-1:0]     ram_wr_addr,
   output logic      [dsr_pkg::BYTE_W-1:0]            ram_wr_data,
   output logic      [$clog2(UNIVERSE_SLOTS)-1:0]     ram_rd_addr,
   output logic                                       desc_valid_ff,
   output dsr_pkg::desc_type                          desc_ff
);

   localparam int AW = $clog2(UNIVERSE_SLOTS);
   localparam logic [dsr_pkg::SLOT_W-1:0]  SLOTS = dsr_pkg::SLOT_W'(UNIVERSE_SLOTS);
   localparam logic [dsr_pkg::FRAME_W-1:0] ACT_N = dsr_pkg::FRAME_W'(ACTIVITY_FRAMES);

   logic [dsr_pkg::SLOT_W-1:0]  slot_index_ff, slot_index_in;
   logic [dsr_pkg::SLOT_W-1:0]  fill_ff, fill_in;
   logic [dsr_pkg::FRAME_W-1:0] frame_count_ff, frame_count_in;
   logic                        poll_ff, poll_in;
   logic [dsr_pkg::SLOT_W-1:0]  own_address_ff, slot_limit_ff;
   logic                        desc_valid_in;
   dsr_pkg::desc_type           desc_in;

   logic [dsr_pkg::SLOT_W:0]    limit_plus2;
   logic [dsr_pkg::SLOT_W-1:0]  index_next;
   logic [dsr_pkg::FRAME_W-1:0] frame_next;
   logic                        own_in_store;

   assign ram_wr_addr = slot_index_ff[AW-1:0];
   assign ram_wr_data = rx_byte;
   assign ram_rd_addr = own_address_ff[AW-1:0];

   always_comb begin
      slot_index_in  = slot_index_ff;
      fill_in        = fill_ff;
      frame_count_in = frame_count_ff;
      poll_in        = poll_ff;
      ram_wr_en      = 1'b0;
      desc_valid_in  = 1'b0;
      desc_in        = '0;
      limit_plus2    = {1'b0, slot_limit_ff} + 11'd2;
      index_next     = (slot_index_ff == dsr_pkg::SLOT_MAX) ? slot_index_ff
                                                            : slot_index_ff + 10'd1;
      frame_next     = frame_count_ff + 6'd1;
      own_in_store   = own_address_ff < SLOTS;

      if (accept) begin
         if (break_seen) begin
            slot_index_in       = '0;
            desc_valid_in       = 1'b1;
            desc_in.kind        = dsr_pkg::RES_BREAK;
            desc_in.level_valid = !poll_ff;
            desc_in.poll        = poll_ff;
            desc_in.rd_ok       = own_in_store && (own_address_ff < fill_ff);
         end else if ({1'b0, slot_index_ff} < limit_plus2) begin
            if (slot_index_ff < SLOTS) begin
               ram_wr_en = 1'b1;
               // store entries are filled as a prefix, so a high-water mark tracks them
               if (slot_index_ff >= fill_ff) begin
                  fill_in = slot_index_ff + 10'd1;
               end
               if (slot_index_ff == '0) begin
                  if (rx_byte == dsr_pkg::START_POLL) begin
                     poll_in = 1'b1;
                  end else if (rx_byte == dsr_pkg::START_DATA) begin
                     poll_in = 1'b0;
                  end
               end
            end
            slot_index_in = index_next;
            if (index_next == SLOTS) begin
               desc_valid_in    = 1'b1;
               desc_in.kind     = dsr_pkg::RES_FRAME;
               desc_in.poll     = poll_in;
               desc_in.rd_ok    = own_in_store && (own_address_ff < fill_in);
               desc_in.fwd      = ram_wr_en && (own_address_ff == slot_index_ff);
               desc_in.fwd_data = rx_byte;
               if (frame_next == ACT_N) begin
                  desc_in.activity = 1'b1;
                  frame_count_in   = '0;
               end else begin
                  frame_count_in   = frame_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_index_ff  <= '0;
         fill_ff        <= '0;
         frame_count_ff <= '0;
         poll_ff        <= 1'b0;
         desc_valid_ff  <= 1'b0;
         own_address_ff <= dsr_pkg::OWN_ADDRESS_RESET;
         slot_limit_ff  <= dsr_pkg::SLOT_LIMIT_RESET;
      end else begin
         slot_index_ff  <= slot_index_in;
         fill_ff        <= fill_in;
         frame_count_ff <= frame_count_in;
         poll_ff        <= poll_in;
         desc_valid_ff  <= desc_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               dsr_pkg::REG_OWN_ADDRESS: own_address_ff <= csr_data;
               dsr_pkg::REG_SLOT_LIMIT:  slot_limit_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

endmodule

`default_nettype wire

// ===== rtl/dsr_queue.sv =====
`default_nettype none

module dsr_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire dsr_pkg::result_type           push_data,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output dsr_pkg::result_type                out_data,
   output logic      [dsr_pkg::QUEUE_AW:0]    count_ff
);

   dsr_pkg::result_type              entry_ff [dsr_pkg::QUEUE_DEPTH];
   logic [dsr_pkg::QUEUE_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [dsr_pkg::QUEUE_AW:0]       count_in;
   logic                             pop;

   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 3'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire
